/* design/irpwd_pkg.sv */
// Package for the IR pulse width decoder: phase encoding, handoff struct,
// configuration register indexes and field widths. No dependencies.
`default_nettype none

package irpwd_pkg;

    localparam int unsigned CFG_WIDTH  = 8;
    localparam int unsigned OUT_CODE_W = 16;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_TIMEOUT   = 2'd0,
        CFG_THRESHOLD = 2'd1,
        CFG_BIT_LIMIT = 2'd2
    } t_cfg_index;

    localparam logic [7:0] TIMEOUT_RST   = 8'd50;
    localparam logic [7:0] THRESHOLD_RST = 8'd10;
    localparam logic [4:0] BIT_LIMIT_RST = 5'd16;
    localparam logic [7:0] COUNT_MAX     = 8'd255;

    // frame phase; the fourth code behaves as waiting for start low
    typedef enum logic [1:0] {
        PH_WAIT_LOW  = 2'd0,
        PH_WAIT_HIGH = 2'd1,
        PH_COUNT     = 2'd2
    } t_phase;

    // end-of-frame handoff from the bit decoder to the result stage
    typedef struct packed {
        logic valid;
        logic by_timeout;
    } t_frame_end;

endpackage

`default_nettype wire

/* design/irpwd_result.sv */
// Result stage of the IR pulse width decoder: repeat substitution, last-code
// store and the output register of the result stream. Uses irpwd_pkg.
`default_nettype none

module irpwd_result
    import irpwd_pkg::*;
#(
    parameter int unsigned CODE_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_frame_end            i_end,
    input  wire logic [CODE_BITS-1:0]  i_code,
    output logic                       o_space,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [OUT_CODE_W-1:0]      o_m_tdata,  // [15:0] code_word
    output logic [1:0]                 o_m_tuser   // [0] repeat_substituted, [1] ended_by_timeout
);

    logic [CODE_BITS+OUT_CODE_W-1:0] code_ext;
    logic [OUT_CODE_W-1:0]           code_lo;
    logic                            is_repeat;

    logic                  r_valid;
    logic [OUT_CODE_W-1:0] r_code;
    logic                  r_repeat;
    logic                  r_timeout;
    logic [OUT_CODE_W-1:0] r_last;

    // code zero-extended or truncated to the output width
    assign code_ext  = {{OUT_CODE_W{1'b0}}, i_code};
    assign code_lo   = code_ext[OUT_CODE_W-1:0];
    assign is_repeat = (i_code >= CODE_BITS'(1)) && (i_code <= CODE_BITS'(4));
    assign o_space   = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= '0;
        end else begin
            if (o_space) begin
                r_valid <= i_end.valid;
            end
            if (o_space && i_end.valid && !is_repeat) begin
                r_last <= code_lo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_end.valid) begin
            r_code    <= is_repeat ? r_last : code_lo;
            r_repeat  <= is_repeat;
            r_timeout <= i_end.by_timeout;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_code;
    assign o_m_tuser  = {r_timeout, r_repeat};

endmodule

`default_nettype wire

/* design/ir_pulse_width_decoder_core.sv */
// IR pulse width decoder, top level: input register, per-sample bit decoder
// and configuration registers. Depends on irpwd_pkg and irpwd_result.
//
// Path: the sample ending the frame is held in the input register, then
//   decoded into the result register, which presents the frame.
// Throughput: one line sample per cycle; the phase/count/shift update is a
//   next-state loop on the state registers. Input stalls only while a
//   result waits in the result register and the receiver holds it off.
// Reset: synchronous, active low; returns to waiting for start low with the
//   last code cleared and registers at 50 / 10 / 16.
`default_nettype none

module ir_pulse_width_decoder_core
    import irpwd_pkg::*;
#(
    parameter int unsigned CODE_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [CFG_WIDTH-1:0]  i_cfg_data,
    // sample stream
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [7:0]            i_s_tdata,  // [0] line_level, [7:1] zero
    // result stream
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [OUT_CODE_W-1:0]      o_m_tdata,  // [15:0] code_word
    output logic [1:0]                 o_m_tuser   // [0] repeat_substituted, [1] ended_by_timeout
);

    // configuration
    logic [7:0] r_timeout;
    logic [7:0] r_threshold;
    logic [4:0] r_bit_limit;

    // input register
    logic r_in_valid;
    logic r_in_level;

    // decoder state
    t_phase                r_phase, n_phase;
    logic [7:0]            r_high_cnt, n_high_cnt;
    logic [4:0]            r_bits_left, n_bits_left;
    logic [CODE_BITS-1:0]  r_shift, n_shift;

    t_frame_end frame_end;
    logic       space;   // result stage can take whatever this step yields
    logic       step;
    logic [7:0] cnt_inc;
    logic [4:0] bits_dec;

    assign step       = r_in_valid && space;
    assign o_s_tready = !r_in_valid || space;

    // config writes; the host writes only while no item is in flight (not enforced here)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RST;
            r_threshold <= THRESHOLD_RST;
            r_bit_limit <= BIT_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data;
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_BIT_LIMIT: r_bit_limit <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_level <= i_s_tdata[0];
        end
    end

    // saturating high count and wrapping bit counter
    assign cnt_inc  = (r_high_cnt == COUNT_MAX) ? r_high_cnt : r_high_cnt + 8'd1;
    assign bits_dec = r_bits_left - 5'd1;

    // one sample per step
    always_comb begin
        n_phase              = r_phase;
        n_high_cnt           = r_high_cnt;
        n_bits_left          = r_bits_left;
        n_shift              = r_shift;
        frame_end.valid      = 1'b0;
        frame_end.by_timeout = 1'b0;

        unique case (r_phase)
            PH_WAIT_HIGH: begin
                if (r_in_level) begin
                    n_phase    = PH_COUNT;
                    n_high_cnt = 8'd1;
                    if (8'd1 >= r_timeout) begin
                        n_shift              = r_shift << 1;
                        frame_end.valid      = 1'b1;
                        frame_end.by_timeout = 1'b1;
                    end
                end
            end
            PH_COUNT: begin
                if (r_in_level) begin
                    n_high_cnt = cnt_inc;
                    if (cnt_inc >= r_timeout) begin
                        n_shift              = r_shift << 1;
                        frame_end.valid      = 1'b1;
                        frame_end.by_timeout = 1'b1;
                    end
                end else begin
                    n_shift     = {r_shift[CODE_BITS-2:0], r_high_cnt > r_threshold};
                    n_high_cnt  = 8'd0;
                    n_bits_left = bits_dec;
                    n_phase     = PH_WAIT_HIGH;
                    if (bits_dec == 5'd0) begin
                        frame_end.valid = 1'b1;
                    end
                end
            end
            default: begin
                // waiting for start low, also the unused phase code
                n_phase = PH_WAIT_LOW;
                if (!r_in_level) begin
                    n_shift     = '0;
                    n_high_cnt  = 8'd0;
                    n_bits_left = r_bit_limit;
                    n_phase     = PH_WAIT_HIGH;
                    if (r_bit_limit == 5'd0) begin
                        frame_end.valid = 1'b1;
                    end
                end
            end
        endcase

        // any frame end returns to idle
        if (frame_end.valid) begin
            n_phase     = PH_WAIT_LOW;
            n_high_cnt  = 8'd0;
            n_bits_left = 5'd0;
        end

        if (!step) begin
            frame_end.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT_LOW;
            r_high_cnt  <= 8'd0;
            r_bits_left <= 5'd0;
            r_shift     <= '0;
        end else if (step) begin
            r_phase     <= n_phase;
            r_high_cnt  <= n_high_cnt;
            r_bits_left <= n_bits_left;
            r_shift     <= n_shift;
        end
    end

    // repeat handling and output register
    irpwd_result #(
        .CODE_BITS (CODE_BITS)
    ) u_result (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_end      (frame_end),
        .i_code     (n_shift),
        .o_space    (space),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // a finished frame always leaves the decoder idle and cleared
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_end.valid |=> (r_phase == PH_WAIT_LOW) && (r_high_cnt == 8'd0)
                            && (r_bits_left == 5'd0))
        else $error("decoder not idle after frame end");

    // counting phase always holds at least the first high tick
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_COUNT) |-> (r_high_cnt != 8'd0))
        else $error("zero high count while counting");

    // inside a frame there is always a bit left to collect
    a_bits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_WAIT_HIGH) || (r_phase == PH_COUNT)) |-> (r_bits_left != 5'd0))
        else $error("frame active with no bits remaining");

endmodule

`default_nettype wire
